// ===== rtl/des_round_function_defines.svh =====
// Assertion macros used by the checker file desrf_checker.sv.
`ifndef DES_ROUND_FUNCTION_DEFINES_SVH
`define DES_ROUND_FUNCTION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DESRF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DESRF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/desrf_pkg.sv =====
package desrf_pkg;

    localparam int RH_W   = 32;
    localparam int RK_W   = 48;
    localparam int FOUT_W = 32;
    localparam int IN_W   = 80;

    // S-box entry i sits at bits [255-4i -: 4] of its row in this table.
    localparam logic [255:0] SBOX_ROM [8] = '{
        256'hE4D12FB83A6C5907_0F74E2D1A6CB9538_41E8D62BFC973A50_FC8249175B3EA06D,
        256'hF18E6B34972DC05A_3D47F28EC01A69B5_0E7BA4D158C6932F_D8A13F42B67C05E9,
        256'hA09E63F51DC7B428_D709346A285ECBF1_D6498F30B12C5AE7_1AD069874FE3B52C,
        256'h7DE3069A1285BC4F_D8B56F03472C1AE9_A690CB7DF13E5284_3F06A1D8945BC72E,
        256'h2C417AB6853FD0E9_EB2C47D150FA3986_421BAD78F9C5630E_B8C71E2D6F09A453,
        256'hC1AF92680D34E75B_AF427C9561DE0B38_9EF528C3704A1DB6_432C95FABE17608D,
        256'h4B2EF08D3C975A61_D0B7491AE35C2F86_14BDC37EAF680592_6BD814A7950FE23C,
        256'hD2846FB1A93E50C7_1FD8A374C56B0E92_7B419CE206ADF358_21E74A8DFC90356B
    };

    // P permutation: output bit (31 - i) takes input bit P_SRC[i].
    localparam logic [4:0] P_SRC [32] = '{
        5'd16, 5'd25, 5'd12, 5'd11, 5'd3,  5'd20, 5'd4,  5'd15,
        5'd31, 5'd17, 5'd9,  5'd6,  5'd27, 5'd14, 5'd1,  5'd22,
        5'd30, 5'd24, 5'd8,  5'd18, 5'd0,  5'd5,  5'd29, 5'd23,
        5'd13, 5'd19, 5'd2,  5'd26, 5'd10, 5'd21, 5'd28, 5'd7
    };

    function automatic logic [3:0] sbox_lookup(input logic [2:0] g, input logic [5:0] v);
        logic [5:0] idx;
        begin
            // row from the outer bits, column from the inner four
            idx = {v[5], v[0], v[4:1]};
            return SBOX_ROM[g][{~idx, 2'b00} +: 4];
        end
    endfunction

    function automatic logic [31:0] p_perm(input logic [31:0] s);
        logic [31:0] o;
        begin
            o = '0;
            for (int i = 0; i < 32; i++)
            begin
                o[31 - i] = s[P_SRC[i]];
            end
            return o;
        end
    endfunction

endpackage

// ===== rtl/desrf_f_core.sv =====
module desrf_f_core
    import desrf_pkg::*;
(
    input  logic [RH_W-1:0]   right_half,
    input  logic [RK_W-1:0]   round_key,
    output logic [FOUT_W-1:0] f_out
);

    logic [31:0] rot;
    logic [63:0] dbl;
    logic [31:0] s_word;

    // E expansion: each 6-bit group is a window of R rotated right by one
    assign rot = {right_half[0], right_half[31:1]};
    assign dbl = {rot, rot};

    always_comb
    begin
        s_word = '0;
        for (int g = 0; g < 8; g++)
        begin
            s_word[31 - 4*g -: 4] = sbox_lookup(3'(g),
                dbl[63 - 4*g -: 6] ^ round_key[47 - 6*g -: 6]);
        end
    end

    assign f_out = p_perm(s_word);

endmodule

// ===== rtl/des_round_function.sv =====
// DES round function f: m_tdata = P(S(E(right_half) xor round_key)).
// One request is taken every cycle while s_tready is high. An accepted request
// is held in the input register; its result is loaded into the result register
// once that register is free and is then offered on the master side. The input
// and result registers around the single-pass E/S-box/P logic give two requests
// of buffering, so s_tready drops only when both hold data and m_tready is low.
// No state is kept between requests.
module des_round_function
    import desrf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // [31:0] right_half, [79:32] round_key
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [FOUT_W-1:0] m_tdata    // [31:0] f_out
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [RH_W-1:0]   rh_reg;
    logic [RK_W-1:0]   rk_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [FOUT_W-1:0] out_data_reg;
    logic [FOUT_W-1:0] f_val;
    logic              out_free;
    logic              s_acc;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign advance  = in_valid_reg && out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_acc)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            rh_reg <= s_tdata[RH_W-1:0];
            rk_reg <= s_tdata[RH_W +: RK_W];
        end
        if (advance)
        begin
            out_data_reg <= f_val;
        end
    end

    desrf_f_core u_f_core (
        .right_half (rh_reg),
        .round_key  (rk_reg),
        .f_out      (f_val)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== rtl/desrf_checker.sv =====
`include "des_round_function_defines.svh"

module desrf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic s_acc;

    assign s_acc = s_tvalid && s_tready;

    // back-pressure upstream only while a result is stalled downstream
    `DESRF_ASSERT_IMPL(a_stall_source, !s_tready, m_tvalid && !m_tready,
        "s_tready low without a stalled result")

    // an accepted request reaches the output once the output register has room
    `DESRF_ASSERT_NEXT(a_latency, s_acc ##1 (m_tready || !m_tvalid), m_tvalid,
        "accepted request did not reach the output")

    // stalled result holds
    `DESRF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "stalled result changed")

endmodule

bind des_round_function desrf_checker u_desrf_checker (.*);

// ===== tb/sv/des_round_function_tb.sv =====
`timescale 1ns / 1ps

module des_round_function_tb;

    import desrf_pkg::*;

    typedef struct packed {
        logic        drain_first;
        logic [47:0] key;
        logic [31:0] half;
    } f_request_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_t;

    // Standard DES S-boxes, S1 in the top 256 bits; entry n of a box is nibble n from its top.
    localparam logic [2047:0] SBOX_BITS = {
        256'hE4D12FB83A6C5907_0F74E2D1A6CB9538_41E8D62BFC973A50_FC8249175B3EA06D,
        256'hF18E6B34972DC05A_3D47F28EC01A69B5_0E7BA4D158C6932F_D8A13F42B67C05E9,
        256'hA09E63F51DC7B428_D709346A285ECBF1_D6498F30B12C5AE7_1AD069874FE3B52C,
        256'h7DE3069A1285BC4F_D8B56F03472C1AE9_A690CB7DF13E5284_3F06A1D8945BC72E,
        256'h2C417AB6853FD0E9_EB2C47D150FA3986_421BAD78F9C5630E_B8C71E2D6F09A453,
        256'hC1AF92680D34E75B_AF427C9561DE0B38_9EF528C3704A1DB6_432C95FABE17608D,
        256'h4B2EF08D3C975A61_D0B7491AE35C2F86_14BDC37EAF680592_6BD814A7950FE23C,
        256'hD2846FB1A93E50C7_1FD8A374C56B0E92_7B419CE206ADF358_21E74A8DFC90356B
    };

    // P permutation in standard 1-based numbering (bit 1 = MSB), first entry on top.
    localparam logic [191:0] P_ORDER = {
        6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
        6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
        6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
        6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
    };

    localparam int N_RANDOM = 1250;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;     // [31:0] right_half, [79:32] round_key
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [FOUT_W-1:0] m_tdata;           // [31:0] f_out

    f_request_t  pending_q[$];
    logic [31:0] f_expect_q[$];

    int f_mismatches = 0;
    int n_requests   = 0;
    int n_results    = 0;
    int n_drains     = 0;

    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    logic     rx_phase   = 1'b0;

    des_round_function i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic logic [31:0] feistel_f(input logic [31:0] half, input logic [47:0] key);
        logic [31:0] rot;
        logic [63:0] dbl;
        logic [5:0]  v;
        logic [31:0] s;
        logic [31:0] o;
        int          g;
        int          i;
        int          idx;
        int          src;
        begin
            // E expansion: rotate right by one, then take overlapping 6-bit windows
            rot = {half[0], half[31:1]};
            dbl = {rot, rot};
            s   = '0;
            for (g = 0; g < 8; g++)
            begin
                v   = dbl[58 - 4 * g +: 6] ^ key[42 - 6 * g +: 6];
                idx = {v[5], v[0]} * 16 + v[4:1];
                s   = {s[27:0], SBOX_BITS[2047 - 256 * g - 4 * idx -: 4]};
            end
            for (i = 0; i < 32; i++)
            begin
                src = P_ORDER[191 - 6 * i -: 6];
                src = 32 - src;
                o[31 - i] = s[src];
            end
            return o;
        end
    endfunction

    task automatic add_request(input logic [31:0] half, input logic [47:0] key,
                               input logic drain);
        f_request_t r;
        begin
            r.drain_first = drain;
            r.key         = key;
            r.half        = half;
            pending_q.push_back(r);
        end
    endtask

    function automatic logic [31:0] rand_word(input int style);
        logic [31:0] w;
        begin
            case (style)
                0:       w = $urandom & $urandom & $urandom;    // sparse
                1:       w = $urandom | $urandom | $urandom;    // dense
                2:       w = 32'h1 << $urandom_range(31, 0);
                default: w = $urandom;
            endcase
            return w;
        end
    endfunction

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Sender: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin : sender
        logic       fire;
        f_request_t nxt;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            burst_left = 8;
            gap_left   = 0;
        end
        else
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                f_expect_q.push_back(feistel_f(s_tdata[31:0], s_tdata[79:32]));
                n_requests++;
            end
            if (!s_tvalid || fire)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_q.size() == 0)
                begin
                    s_tvalid <= 1'b0;
                end
                else if (pending_q[0].drain_first && f_expect_q.size() != 0)
                begin
                    // hold until every outstanding result has come back
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    nxt = pending_q.pop_front();
                    if (nxt.drain_first)
                        n_drains++;
                    s_tdata  <= {nxt.key, nxt.half};
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(7, 0) == 0)
                        begin
                            burst_left = 64;
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(24, 1);
                            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                        end
                    end
                end
            end
        end
    end

    // Receiver: stall pattern switches to a randomly chosen mode at the end of each random-length run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_mode  = RX_OPEN;
            rx_left  = 0;
            rx_phase = 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(3, 0));
                rx_left = $urandom_range(96, 16);
            end
            rx_left--;
            rx_phase = ~rx_phase;
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(1, 0));
                RX_SPARSE: m_tready <= ($urandom_range(3, 0) == 0);
                default:   m_tready <= rx_phase;
            endcase
        end
    end

    // Compare each returned result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        logic [31:0] want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (f_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual f_out=%08h",
                         $time, m_tdata);
                f_mismatches++;
            end
            else
            begin
                want = f_expect_q.pop_front();
                if (m_tdata !== want)
                begin
                    $display("%0t: f_out mismatch, expected %08h, actual %08h",
                             $time, want, m_tdata);
                    f_mismatches++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        logic [47:0] key;
        // corner values of both fields
        add_request(32'h00000000, 48'h000000000000, 1'b0);
        add_request(32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 1'b0);
        add_request(32'hFFFFFFFF, 48'h000000000000, 1'b0);
        add_request(32'h00000000, 48'hFFFFFFFFFFFF, 1'b0);
        add_request(32'hAAAAAAAA, 48'h555555555555, 1'b0);
        add_request(32'h55555555, 48'hAAAAAAAAAAAA, 1'b0);
        // wraparound bits of the expansion
        add_request(32'h80000000, 48'h000000000000, 1'b0);
        add_request(32'h00000001, 48'h000000000000, 1'b0);
        // row and column extremes in every S-box
        add_request(32'h00000000, 48'h820820820820, 1'b0);
        add_request(32'h00000000, 48'h041041041041, 1'b0);
        add_request(32'h00000000, 48'h79E79E79E79E, 1'b0);
        add_request(32'h00000000, 48'hFC0FC0FC0FC0, 1'b0);
        add_request(32'h00000000, 48'h03F03F03F03F, 1'b0);
        add_request(32'h12345678, 48'hFEDCBA987654, 1'b1);
        add_request(32'hF0F0F0F0, 48'h0F0F0F0F0F0F, 1'b0);
        add_request(32'h7FFFFFFF, 48'h7FFFFFFFFFFF, 1'b0);
        add_request(32'hFFFFFFFE, 48'hFFFFFFFFFFFE, 1'b0);
        add_request(32'hDEADBEEF, 48'h0123456789AB, 1'b0);
        for (i = 0; i < N_RANDOM; i++)
        begin
            key = 48'({rand_word($urandom_range(3, 0)), rand_word($urandom_range(3, 0))});
            add_request(rand_word($urandom_range(3, 0)), key,
                        (i == 0) || ($urandom_range(199, 0) == 0));
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (f_expect_q.size() != 0)
            @(posedge clk);
        // let any stray result surface
        repeat (10) @(posedge clk);

        $display("Sent %0d round-function requests (corner keys, S-box rows/columns, random)",
                 n_requests);
        $display("Checked %0d results, %0d full drains, %0d mismatches",
                 n_results, n_drains, f_mismatches);
        if (f_mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
